// ===== rtl/tzt_pkg.sv =====
// ----------------------------------------------------------------------------
// tzt_pkg
// Shared types, constants and helpers of the two-zone hysteresis thermostat.
// ----------------------------------------------------------------------------
package tzt_pkg;

	// Register map: register n lies at byte address 4*n.
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_BOTTOM_SETPOINT    = 3'd0,
		REG_BOTTOM_OVER        = 3'd1,
		REG_BOTTOM_UNDER       = 3'd2,
		REG_GLYCOL_SETPOINT    = 3'd3,
		REG_GLYCOL_OVER        = 3'd4,
		REG_GLYCOL_UNDER       = 3'd5,
		REG_ACTIVATION_SECONDS = 3'd6
	} reg_index_t;

	// Field widths.
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned TEMP_W  = 13;
	localparam int unsigned SETP_W  = 12;
	localparam int unsigned BAND_W  = 11;
	localparam int unsigned SECS_W  = 8;
	localparam int unsigned LIMIT_W = TEMP_W + 1;
	localparam int unsigned THR_W   = 18;

	typedef logic [TIME_W-1:0]         time_ms_t;
	typedef logic signed [TEMP_W-1:0]  temp_t;
	typedef logic signed [SETP_W-1:0]  setpoint_t;
	typedef logic [BAND_W-1:0]         band_t;
	typedef logic [SECS_W-1:0]         secs_t;
	typedef logic signed [LIMIT_W-1:0] limit_t;
	typedef logic [THR_W-1:0]          thr_ms_t;

	// Readings outside this open range count as invalid.
	localparam temp_t TEMP_LOW_LIMIT  = -13'sd800;
	localparam temp_t TEMP_HIGH_LIMIT = 13'sd1920;

	localparam time_ms_t TIME_FORCED = '1;
	localparam int unsigned MS_PER_SECOND = 1000;

	// Register reset values.
	localparam setpoint_t BOTTOM_SETPOINT_RST = 12'sd1040;
	localparam band_t     BOTTOM_OVER_RST     = 11'd16;
	localparam band_t     BOTTOM_UNDER_RST    = 11'd16;
	localparam setpoint_t GLYCOL_SETPOINT_RST = 12'sd448;
	localparam band_t     GLYCOL_OVER_RST     = 11'd32;
	localparam band_t     GLYCOL_UNDER_RST    = 11'd32;
	localparam secs_t     ACTIVATION_RST      = 8'd10;

	// Whole elapsed seconds exceed secs exactly when the elapsed milliseconds
	// reach (secs + 1) * 1000, which avoids a divider on the time path.
	function automatic thr_ms_t ms_threshold(input secs_t secs);
		thr_ms_t s1;
		begin
			s1 = {{(THR_W-SECS_W){1'b0}}, secs} + thr_ms_t'(1);
			ms_threshold = thr_ms_t'(s1 * thr_ms_t'(MS_PER_SECOND));
		end
	endfunction

	// A reading is usable when present and strictly inside the limits.
	function automatic logic reading_valid(input temp_t t, input logic present);
		reading_valid = present && (t > TEMP_LOW_LIMIT) && (t < TEMP_HIGH_LIMIT);
	endfunction

	function automatic limit_t band_plus(input setpoint_t sp, input band_t b);
		band_plus = limit_t'(sp) + limit_t'({1'b0, b});
	endfunction

	function automatic limit_t band_minus(input setpoint_t sp, input band_t b);
		band_minus = limit_t'(sp) - limit_t'({1'b0, b});
	endfunction

endpackage

// ===== rtl/tzt_tick_if.sv =====
// ----------------------------------------------------------------------------
// tzt_tick_if
// Input channel: one time stamp and two zone readings per item.
// ----------------------------------------------------------------------------
interface tzt_tick_if;
	logic             valid;
	logic             ready;
	tzt_pkg::time_ms_t now_ms;
	tzt_pkg::temp_t   bottom_temp;
	logic             bottom_present;
	tzt_pkg::temp_t   glycol_temp;
	logic             glycol_present;

	modport source(
		output valid, now_ms, bottom_temp, bottom_present, glycol_temp, glycol_present,
		input ready
	);
	modport sink(
		input valid, now_ms, bottom_temp, bottom_present, glycol_temp, glycol_present,
		output ready
	);
endinterface

// ===== rtl/tzt_result_if.sv =====
// ----------------------------------------------------------------------------
// tzt_result_if
// Output channel: refresh and evaluation flags and both cooler states.
// ----------------------------------------------------------------------------
interface tzt_result_if;
	logic valid;
	logic ready;
	logic refresh_request;
	logic evaluated;
	logic bottom_cooling;
	logic glycol_cooling;

	modport source(
		output valid, refresh_request, evaluated, bottom_cooling, glycol_cooling,
		input ready
	);
	modport sink(
		input valid, refresh_request, evaluated, bottom_cooling, glycol_cooling,
		output ready
	);
endinterface

// ===== rtl/two_zone_hysteresis_thermostat.sv =====
// ----------------------------------------------------------------------------
// two_zone_hysteresis_thermostat
// Bang-bang control of two cooling zones with hysteresis and timed evaluation.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the result register is
// stalled. The item is captured in an input register, the elapsed-time
// compares and the hysteresis rules run combinationally against the stored
// time stamps and cooler states, and the outcome lands in the result register
// as the state registers update, so each item sees the state the one before
// left; a stalled result register holds the input register, and the input
// side stops taking items only when both are full. The user must write
// configuration through the APB port only while no item is in flight; the
// block does not enforce this. The refresh and evaluation thresholds in
// milliseconds are worked out when activation_seconds is written.
module two_zone_hysteresis_thermostat (
	input  logic                          clk,
	input  logic                          arst_n,
	tzt_tick_if.sink                      tick,
	tzt_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tzt_pkg::PADDR_W-1:0]   paddr,
	input  logic [tzt_pkg::PDATA_W-1:0]   pwdata,
	output logic [tzt_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	// Configuration registers.
	tzt_pkg::setpoint_t bottom_setpoint_q;
	tzt_pkg::band_t     bottom_over_q;
	tzt_pkg::band_t     bottom_under_q;
	tzt_pkg::setpoint_t glycol_setpoint_q;
	tzt_pkg::band_t     glycol_over_q;
	tzt_pkg::band_t     glycol_under_q;
	tzt_pkg::secs_t     activation_q;
	tzt_pkg::thr_ms_t   thr_eval_q;
	tzt_pkg::thr_ms_t   thr_refresh_q;

	tzt_pkg::reg_index_t reg_idx;
	logic                cfg_wr;

	// Input stage.
	logic              v_s1;
	tzt_pkg::time_ms_t now_s1;
	tzt_pkg::temp_t    bt_s1;
	logic              bp_s1;
	tzt_pkg::temp_t    gt_s1;
	logic              gp_s1;

	// Controller state.
	tzt_pkg::time_ms_t last_refresh_q;
	tzt_pkg::time_ms_t last_eval_q;
	logic              bottom_on_q;
	logic              glycol_on_q;

	// Result register.
	logic out_v_q;
	logic refresh_q;
	logic eval_q;
	logic bottom_cool_q;
	logic glycol_cool_q;

	logic              advance;
	logic              forced;
	tzt_pkg::time_ms_t since_refresh;
	tzt_pkg::time_ms_t since_eval;
	logic              do_refresh;
	logic              do_eval;
	logic              bottom_ok;
	logic              glycol_ok;
	logic              bottom_next;
	logic              glycol_next;

	assign pready  = 1'b1;
	assign reg_idx = tzt_pkg::reg_index_t'(paddr[tzt_pkg::PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_setpoint_q <= tzt_pkg::BOTTOM_SETPOINT_RST;
			bottom_over_q     <= tzt_pkg::BOTTOM_OVER_RST;
			bottom_under_q    <= tzt_pkg::BOTTOM_UNDER_RST;
			glycol_setpoint_q <= tzt_pkg::GLYCOL_SETPOINT_RST;
			glycol_over_q     <= tzt_pkg::GLYCOL_OVER_RST;
			glycol_under_q    <= tzt_pkg::GLYCOL_UNDER_RST;
			activation_q      <= tzt_pkg::ACTIVATION_RST;
			thr_eval_q        <= tzt_pkg::ms_threshold(tzt_pkg::ACTIVATION_RST);
			thr_refresh_q     <= tzt_pkg::ms_threshold(tzt_pkg::ACTIVATION_RST >> 1);
		end else if (cfg_wr) begin
			case (reg_idx)
				tzt_pkg::REG_BOTTOM_SETPOINT: begin
					bottom_setpoint_q <= tzt_pkg::setpoint_t'(pwdata[tzt_pkg::SETP_W-1:0]);
				end
				tzt_pkg::REG_BOTTOM_OVER: begin
					bottom_over_q <= pwdata[tzt_pkg::BAND_W-1:0];
				end
				tzt_pkg::REG_BOTTOM_UNDER: begin
					bottom_under_q <= pwdata[tzt_pkg::BAND_W-1:0];
				end
				tzt_pkg::REG_GLYCOL_SETPOINT: begin
					glycol_setpoint_q <= tzt_pkg::setpoint_t'(pwdata[tzt_pkg::SETP_W-1:0]);
				end
				tzt_pkg::REG_GLYCOL_OVER: begin
					glycol_over_q <= pwdata[tzt_pkg::BAND_W-1:0];
				end
				tzt_pkg::REG_GLYCOL_UNDER: begin
					glycol_under_q <= pwdata[tzt_pkg::BAND_W-1:0];
				end
				tzt_pkg::REG_ACTIVATION_SECONDS: begin
					activation_q  <= pwdata[tzt_pkg::SECS_W-1:0];
					thr_eval_q    <= tzt_pkg::ms_threshold(pwdata[tzt_pkg::SECS_W-1:0]);
					thr_refresh_q <= tzt_pkg::ms_threshold({1'b0, pwdata[tzt_pkg::SECS_W-1:1]});
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			tzt_pkg::REG_BOTTOM_SETPOINT:    prdata[tzt_pkg::SETP_W-1:0] = bottom_setpoint_q;
			tzt_pkg::REG_BOTTOM_OVER:        prdata[tzt_pkg::BAND_W-1:0] = bottom_over_q;
			tzt_pkg::REG_BOTTOM_UNDER:       prdata[tzt_pkg::BAND_W-1:0] = bottom_under_q;
			tzt_pkg::REG_GLYCOL_SETPOINT:    prdata[tzt_pkg::SETP_W-1:0] = glycol_setpoint_q;
			tzt_pkg::REG_GLYCOL_OVER:        prdata[tzt_pkg::BAND_W-1:0] = glycol_over_q;
			tzt_pkg::REG_GLYCOL_UNDER:       prdata[tzt_pkg::BAND_W-1:0] = glycol_under_q;
			tzt_pkg::REG_ACTIVATION_SECONDS: prdata[tzt_pkg::SECS_W-1:0] = activation_q;
			default:                         prdata = '0;
		endcase
	end

	// The input stage moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance    = v_s1 && (!out_v_q || result.ready);
	assign tick.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			now_s1 <= tick.now_ms;
			bt_s1  <= tick.bottom_temp;
			bp_s1  <= tick.bottom_present;
			gt_s1  <= tick.glycol_temp;
			gp_s1  <= tick.glycol_present;
		end
	end

	// Elapsed times wrap modulo 2^32.
	assign forced        = (now_s1 == tzt_pkg::TIME_FORCED);
	assign since_refresh = now_s1 - last_refresh_q;
	assign since_eval    = now_s1 - last_eval_q;
	assign do_refresh    = forced || (since_refresh >= tzt_pkg::time_ms_t'(thr_refresh_q));
	assign do_eval       = forced || (since_eval >= tzt_pkg::time_ms_t'(thr_eval_q));

	assign bottom_ok = tzt_pkg::reading_valid(bt_s1, bp_s1);
	assign glycol_ok = tzt_pkg::reading_valid(gt_s1, gp_s1);

	// The start and stop bands cannot overlap, so one compare per state
	// suffices. The bottom zone stops at the lower bound, the glycol zone
	// only below it.
	always_comb begin
		bottom_next = bottom_on_q;
		glycol_next = glycol_on_q;
		if (do_eval && bottom_ok) begin
			if (!bottom_on_q) begin
				bottom_next = tzt_pkg::limit_t'(bt_s1) >
					tzt_pkg::band_plus(bottom_setpoint_q, bottom_over_q);
			end else begin
				bottom_next = !(tzt_pkg::limit_t'(bt_s1) <=
					tzt_pkg::band_minus(bottom_setpoint_q, bottom_under_q));
			end
		end
		if (do_eval && glycol_ok) begin
			if (!glycol_on_q) begin
				glycol_next = tzt_pkg::limit_t'(gt_s1) >
					tzt_pkg::band_plus(glycol_setpoint_q, glycol_over_q);
			end else begin
				glycol_next = !(tzt_pkg::limit_t'(gt_s1) <
					tzt_pkg::band_minus(glycol_setpoint_q, glycol_under_q));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_refresh_q <= '0;
			last_eval_q    <= '0;
			bottom_on_q    <= 1'b0;
			glycol_on_q    <= 1'b0;
		end else if (advance) begin
			if (do_refresh) begin
				last_refresh_q <= now_s1;
			end
			if (do_eval) begin
				last_eval_q <= now_s1;
			end
			bottom_on_q <= bottom_next;
			glycol_on_q <= glycol_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			refresh_q     <= do_refresh;
			eval_q        <= do_eval;
			bottom_cool_q <= bottom_next;
			glycol_cool_q <= glycol_next;
		end
	end

	assign result.valid           = out_v_q;
	assign result.refresh_request = refresh_q;
	assign result.evaluated       = eval_q;
	assign result.bottom_cooling  = bottom_cool_q;
	assign result.glycol_cooling  = glycol_cool_q;

endmodule

// ===== rtl/tzt_checker.sv =====
// ----------------------------------------------------------------------------
// tzt_checker
// Port-level checks of the thermostat, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tzt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic refresh_request,
	input logic evaluated,
	input logic bottom_cooling,
	input logic glycol_cooling
);

	logic [1:0] pending_q;
	logic       bottom_prev_q;
	logic       glycol_prev_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Items accepted whose result has not been delivered yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// Cooler states of the last delivered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_prev_q <= 1'b0;
			glycol_prev_q <= 1'b0;
		end else if (out_acc) begin
			bottom_prev_q <= bottom_cooling;
			glycol_prev_q <= glycol_cooling;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(refresh_request) &&
		$stable(evaluated) && $stable(bottom_cooling) && $stable(glycol_cooling))
		else $error("result item changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result item without an accepted input item");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more items in flight than the two stages hold");

	a_cool_only_on_eval: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !evaluated |->
		bottom_cooling == bottom_prev_q && glycol_cooling == glycol_prev_q)
		else $error("cooler state changed on an item without evaluation");

endmodule

bind two_zone_hysteresis_thermostat tzt_checker u_tzt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (tick.valid),
	.in_ready        (tick.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.refresh_request (result.refresh_request),
	.evaluated       (result.evaluated),
	.bottom_cooling  (result.bottom_cooling),
	.glycol_cooling  (result.glycol_cooling)
);
